// File: rtl/core/drw_pkg.sv
// Shared constants and types of the diagnostic read/write-by-identifier responder.
package drw_pkg;

    // Storage sizes
    localparam int NUM_ENTRIES = 3;
    localparam int CFG_ENTRIES = 3;
    localparam int MSG_BYTES   = 7;
    localparam int HDR_BYTES   = 3;
    localparam int VAL_BYTES   = 4;
    localparam int RESP_BYTES  = HDR_BYTES + VAL_BYTES;
    localparam int POS_W       = $clog2(MSG_BYTES + 1);
    localparam int IDX_W       = $clog2(MSG_BYTES);
    localparam int RIDX_W      = $clog2(RESP_BYTES);
    localparam int RLEN_W      = $clog2(RESP_BYTES + 1);
    localparam int EIDX_W      = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int PADDR_W     = 5;

    // Protocol bytes
    localparam logic [7:0] SVC_READ   = 8'h22;
    localparam logic [7:0] SVC_WRITE  = 8'h2E;
    localparam logic [7:0] POS_OFFSET = 8'h40;
    localparam logic [7:0] NEG_ID     = 8'h7F;
    localparam logic [7:0] NRC_RANGE  = 8'h31;
    localparam logic [2:0] LEN_MAX    = 3'd4;

    // Register indexes
    localparam logic [2:0] REG_COUNT = 3'd0;
    localparam logic [2:0] REG_ID0   = 3'd1;
    localparam logic [2:0] REG_ID1   = 3'd2;
    localparam logic [2:0] REG_ID2   = 3'd3;
    localparam logic [2:0] REG_LEN0  = 3'd4;
    localparam logic [2:0] REG_LEN1  = 3'd5;
    localparam logic [2:0] REG_LEN2  = 3'd6;

    typedef struct packed {
        logic [1:0]                        entry_count;
        logic [CFG_ENTRIES-1:0][15:0]      entry_id;
        logic [CFG_ENTRIES-1:0][2:0]       entry_len;
    } t_cfg;

    typedef struct packed {
        logic store_wr;
        logic decode;
        logic send_adv;
    } t_cmd;

    typedef struct packed {
        logic has_resp;
        logic send_last;
    } t_sts;

endpackage

// File: rtl/core/drw_req_if.sv
// Request byte channel.
interface drw_req_if;
    logic       valid;
    logic       ready;
    logic [7:0] req_byte;
    logic       req_last;

    modport source (output valid, output req_byte, output req_last, input ready);
    modport sink   (input valid, input req_byte, input req_last, output ready);
endinterface

// File: rtl/core/drw_resp_if.sv
// Response byte channel.
interface drw_resp_if;
    logic       valid;
    logic       ready;
    logic [7:0] resp_byte;
    logic       resp_last;

    modport source (output valid, output resp_byte, output resp_last, input ready);
    modport sink   (input valid, input resp_byte, input resp_last, output ready);
endinterface

// File: rtl/core/drw_regs.sv
// Configuration register file behind the APB-style port.
module drw_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [drw_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output drw_pkg::t_cfg                o_cfg
);
    import drw_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] w_idx;
    logic       w_wr;

    assign w_idx  = paddr[PADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.entry_count <= 2'd0;
            for (int i = 0; i < CFG_ENTRIES; i++) begin
                r_cfg.entry_id[i]  <= 16'd0;
                r_cfg.entry_len[i] <= LEN_MAX;
            end
        end else if (w_wr) begin
            case (w_idx)
                REG_COUNT: r_cfg.entry_count  <= pwdata[1:0];
                REG_ID0:   r_cfg.entry_id[0]  <= pwdata[15:0];
                REG_ID1:   r_cfg.entry_id[1]  <= pwdata[15:0];
                REG_ID2:   r_cfg.entry_id[2]  <= pwdata[15:0];
                REG_LEN0:  r_cfg.entry_len[0] <= pwdata[2:0];
                REG_LEN1:  r_cfg.entry_len[1] <= pwdata[2:0];
                REG_LEN2:  r_cfg.entry_len[2] <= pwdata[2:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = 32'd0;
        case (w_idx)
            REG_COUNT: prdata = {30'd0, r_cfg.entry_count};
            REG_ID0:   prdata = {16'd0, r_cfg.entry_id[0]};
            REG_ID1:   prdata = {16'd0, r_cfg.entry_id[1]};
            REG_ID2:   prdata = {16'd0, r_cfg.entry_id[2]};
            REG_LEN0:  prdata = {29'd0, r_cfg.entry_len[0]};
            REG_LEN1:  prdata = {29'd0, r_cfg.entry_len[1]};
            REG_LEN2:  prdata = {29'd0, r_cfg.entry_len[2]};
            default:   prdata = 32'd0;
        endcase
    end
endmodule

// File: rtl/core/drw_ctrl.sv
// Sequencing state machine: collect request, decode, send response.
module drw_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_last,
    input  logic           i_out_ready,
    input  drw_pkg::t_sts  i_sts,
    output logic           o_in_ready,
    output logic           o_out_valid,
    output drw_pkg::t_cmd  o_cmd
);
    import drw_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_DECODE = 2'd1;
    localparam logic [1:0] ST_SEND   = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = (r_state == ST_SEND);

    always_comb begin
        n_state        = r_state;
        o_cmd.store_wr = 1'b0;
        o_cmd.decode   = 1'b0;
        o_cmd.send_adv = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.store_wr = 1'b1;
                    if (i_in_last) begin
                        n_state = ST_DECODE;
                    end
                end
            end
            ST_DECODE: begin
                o_cmd.decode = 1'b1;
                n_state      = i_sts.has_resp ? ST_SEND : ST_IDLE;
            end
            ST_SEND: begin
                if (i_out_ready) begin
                    o_cmd.send_adv = 1'b1;
                    if (i_sts.send_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

// File: rtl/core/drw_dp.sv
// Datapath: message store, entry values, identifier search and response buffer.
module drw_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  drw_pkg::t_cmd  i_cmd,
    input  drw_pkg::t_cfg  i_cfg,
    input  logic [7:0]     i_req_byte,
    output drw_pkg::t_sts  o_sts,
    output logic [7:0]     o_resp_byte
);
    import drw_pkg::*;

    logic [MSG_BYTES-1:0][7:0]   r_store;
    logic [POS_W-1:0]            r_pos;
    logic [NUM_ENTRIES-1:0][31:0] r_values;
    logic [RESP_BYTES-1:0][7:0]  r_resp;
    logic [RLEN_W-1:0]           r_resp_len;
    logic [RIDX_W-1:0]           r_ridx;

    logic [7:0]                  w_svc;
    logic [15:0]                 w_id;
    logic                        w_is_rd;
    logic                        w_is_wr;
    logic                        w_hit;
    logic [EIDX_W-1:0]           w_ent;
    logic [2:0]                  w_len;
    logic [RESP_BYTES-1:0][7:0]  n_resp;
    logic [RLEN_W-1:0]           n_resp_len;

    assign w_svc   = r_store[0];
    assign w_id    = {r_store[1], r_store[2]};
    assign w_is_rd = (w_svc == SVC_READ);
    assign w_is_wr = (w_svc == SVC_WRITE);

    // first registered entry with a matching identifier wins
    always_comb begin
        w_hit = 1'b0;
        w_ent = '0;
        for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
            if ((2'(i) < i_cfg.entry_count) && (i_cfg.entry_id[i] == w_id)) begin
                w_hit = 1'b1;
                w_ent = EIDX_W'(i);
            end
        end
    end

    always_comb begin
        w_len      = (i_cfg.entry_len[w_ent] > LEN_MAX) ? LEN_MAX : i_cfg.entry_len[w_ent];
        n_resp     = '0;
        n_resp_len = RLEN_W'(HDR_BYTES);
        if (!w_hit) begin
            n_resp[0] = NEG_ID;
            n_resp[1] = w_svc;
            n_resp[2] = NRC_RANGE;
        end else begin
            n_resp[0] = w_svc + POS_OFFSET;
            n_resp[1] = r_store[1];
            n_resp[2] = r_store[2];
            if (w_is_rd) begin
                n_resp_len = RLEN_W'(HDR_BYTES) + RLEN_W'(w_len);
                for (int k = 0; k < VAL_BYTES; k++) begin
                    n_resp[HDR_BYTES + k] = r_values[w_ent][8*k +: 8];
                end
            end
        end
    end

    assign o_sts.has_resp  = w_is_rd || w_is_wr;
    assign o_sts.send_last = (RLEN_W'(r_ridx) == r_resp_len - RLEN_W'(1));
    assign o_resp_byte     = r_resp[r_ridx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_store  <= '0;
            r_pos    <= '0;
            r_values <= '0;
            r_ridx   <= '0;
        end else begin
            // drop bytes past the end of the store
            if (i_cmd.store_wr && (r_pos < POS_W'(MSG_BYTES))) begin
                r_store[r_pos[IDX_W-1:0]] <= i_req_byte;
                r_pos                     <= r_pos + POS_W'(1);
            end
            if (i_cmd.decode) begin
                r_store <= '0;
                r_pos   <= '0;
                r_ridx  <= '0;
                if (w_is_wr && w_hit) begin
                    r_values[w_ent] <= {r_store[6], r_store[5], r_store[4], r_store[3]};
                end
            end
            if (i_cmd.send_adv) begin
                r_ridx <= r_ridx + RIDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.decode) begin
            r_resp     <= n_resp;
            r_resp_len <= n_resp_len;
        end
    end
endmodule

// File: rtl/core/diag_read_write_by_id_responder.sv
// Top level of the diagnostic read/write-by-identifier responder.
// Request bytes are taken one per cycle while idle, service byte first, into a seven-byte
// message store; bytes past the seventh are dropped. The cycle after the last byte is a
// decode cycle: the identifier is compared against the registered entries at once, a
// write with a matching identifier updates the entry value, and the whole response (3 to
// 7 bytes) is loaded into a response buffer. The response then goes out one word per
// cycle while the sink is ready. The input is held off during decode and send; a request
// with an unknown service is answered with nothing. Registers are written over the
// APB-style port at byte address 4*index and should be changed only while idle.
module diag_read_write_by_id_responder (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    drw_req_if.sink                      i_req,
    drw_resp_if.source                   o_resp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [drw_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import drw_pkg::*;

    t_cfg w_cfg;
    t_cmd w_cmd;
    t_sts w_sts;

    // configuration registers
    drw_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // sequencer: owns both handshakes
    drw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_in_last   (i_req.req_last),
        .i_out_ready (o_resp.ready),
        .i_sts       (w_sts),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_resp.valid),
        .o_cmd       (w_cmd)
    );

    // store, search and response buffer
    drw_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cfg       (w_cfg),
        .i_req_byte  (i_req.req_byte),
        .o_sts       (w_sts),
        .o_resp_byte (o_resp.resp_byte)
    );

    // last word flag comes straight from the buffer index compare
    assign o_resp.resp_last = w_sts.send_last;

    // never take a request word while a response word is offered
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_req.ready && o_resp.valid))
        else $error("request accepted while response pending");

    // the last request word always leads to a decode cycle with input held
    a_decode_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready && i_req.req_last) |=> (!i_req.ready && !o_resp.valid))
        else $error("no decode cycle after last request word");

    // once the last response word is taken, the response channel goes quiet
    a_resp_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_resp.valid && o_resp.ready && o_resp.resp_last) |=> (!o_resp.valid && i_req.ready))
        else $error("response continued past its last word");

endmodule

// File: tb/diag_read_write_by_id_responder_tb.sv
// Testbench of the diagnostic read/write-by-identifier responder, with its own predictor.
module diag_read_write_by_id_responder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import drw_pkg::*;

    // Cycles to let pass after the last expected word, so that a request that
    // causes no response has surely finished its decode cycle.
    localparam int SETTLE_CYCLES = 16;
    // Cycles without any handshake or register access before the run is given up.
    localparam int IDLE_LIMIT    = 2000;
    localparam int MAX_REPORTS   = 10;
    localparam int PHASE_WORDS   = 95;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_resp_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    drw_req_if  req_ch ();
    drw_resp_if resp_ch ();

    diag_read_write_by_id_responder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_resp  (resp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Predictor state: message buffer, fill position, stored entry values and a
    // copy of the registers as last written.
    logic [7:0]  msg_buf [MSG_BYTES];
    int unsigned msg_fill;
    logic [31:0] entry_value [NUM_ENTRIES];
    logic [1:0]  cfg_count;
    logic [15:0] cfg_id  [CFG_ENTRIES];
    logic [2:0]  cfg_len [CFG_ENTRIES];

    // Response words still owed by the block, oldest first.
    t_resp_word resp_words_due [$];

    int req_idle_pct   = 0;
    int resp_stall_pct = 0;
    int mismatch_count = 0;
    int req_words_sent = 0;
    int requests_sent  = 0;
    int resp_words_seen = 0;
    int quiet_cycles   = 0;

    function automatic void owe_word(input logic [7:0] data, input logic last);
        t_resp_word w;
        w.data = data;
        w.last = last;
        resp_words_due.push_back(w);
    endfunction

    // Advance the predictor by one accepted request word and queue the response
    // words that it causes.
    function automatic void predict_request_word(input logic [7:0] b, input logic last);
        logic [7:0]  svc;
        logic [15:0] did;
        int          hit;
        int          searched;
        int          nbytes;
        logic [31:0] v;
        // Words past the buffer are dropped; the position saturates.
        if (msg_fill < MSG_BYTES) begin
            msg_buf[msg_fill] = b;
            msg_fill++;
        end
        if (!last) return;
        svc = msg_buf[0];
        did = {msg_buf[1], msg_buf[2]};
        if (svc == SVC_READ || svc == SVC_WRITE) begin
            hit = -1;
            searched = (cfg_count > NUM_ENTRIES) ? NUM_ENTRIES : cfg_count;
            // Scan downward so that the lowest matching entry wins.
            for (int i = searched - 1; i >= 0; i--) begin
                if (cfg_id[i] == did) hit = i;
            end
            if (hit < 0) begin
                owe_word(NEG_ID, 1'b0);
                owe_word(svc, 1'b0);
                owe_word(NRC_RANGE, 1'b1);
            end else if (svc == SVC_READ) begin
                nbytes = (cfg_len[hit] > LEN_MAX) ? LEN_MAX : cfg_len[hit];
                v = entry_value[hit];
                owe_word(svc + POS_OFFSET, 1'b0);
                owe_word(msg_buf[1], 1'b0);
                owe_word(msg_buf[2], nbytes == 0);
                for (int i = 0; i < nbytes; i++) begin
                    owe_word(v[8*i +: 8], i == nbytes - 1);
                end
            end else begin
                entry_value[hit] = {msg_buf[6], msg_buf[5], msg_buf[4], msg_buf[3]};
                owe_word(svc + POS_OFFSET, 1'b0);
                owe_word(msg_buf[1], 1'b0);
                owe_word(msg_buf[2], 1'b1);
            end
        end
        // The buffer is cleared after every request, so missing bytes read as zero.
        for (int i = 0; i < MSG_BYTES; i++) msg_buf[i] = 8'h00;
        msg_fill = 0;
    endfunction

    function automatic logic [31:0] cfg_reg_value(input logic [2:0] idx);
        case (idx)
            REG_COUNT: return {30'b0, cfg_count};
            REG_ID0:   return {16'b0, cfg_id[0]};
            REG_ID1:   return {16'b0, cfg_id[1]};
            REG_ID2:   return {16'b0, cfg_id[2]};
            REG_LEN0:  return {29'b0, cfg_len[0]};
            REG_LEN1:  return {29'b0, cfg_len[1]};
            default:   return {29'b0, cfg_len[2]};
        endcase
    endfunction

    function automatic logic [31:0] cfg_reg_mask(input logic [2:0] idx);
        if (idx == REG_COUNT) return 32'h3;
        if (idx == REG_ID0 || idx == REG_ID1 || idx == REG_ID2) return 32'hFFFF;
        return 32'h7;
    endfunction

    function automatic void report_mismatch(input string what, input logic [31:0] exp_val,
                                            input logic [31:0] got_val);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] mismatch on %s: expected %h, got %h", $realtime, what,
                     exp_val, got_val);
    endfunction

    // Response side: stall at random and check each accepted word against the
    // oldest owed one.
    always @(posedge i_clk) begin
        t_resp_word exp_word;
        if (i_rst_n && resp_ch.valid && resp_ch.ready) begin
            resp_words_seen++;
            if (resp_words_due.size() == 0) begin
                report_mismatch("unexpected response word", 32'h0,
                                {23'b0, resp_ch.resp_byte, resp_ch.resp_last});
            end else begin
                exp_word = resp_words_due.pop_front();
                if (exp_word.data !== resp_ch.resp_byte)
                    report_mismatch("resp_byte", exp_word.data, resp_ch.resp_byte);
                if (exp_word.last !== resp_ch.resp_last)
                    report_mismatch("resp_last", exp_word.last, resp_ch.resp_last);
            end
        end
        resp_ch.ready <= ($urandom_range(99) >= resp_stall_pct);
    end

    // Watchdog: any handshake or register access restarts the count.
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (resp_ch.valid && resp_ch.ready) || psel
            || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d words still owed",
                     IDLE_LIMIT, resp_words_due.size());
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Register write: setup cycle, then access cycle; the register takes the
    // value at the edge that ends the access. An idle gap follows so that the
    // next access starts in a fresh time step.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_COUNT: cfg_count  = val[1:0];
            REG_ID0:   cfg_id[0]  = val[15:0];
            REG_ID1:   cfg_id[1]  = val[15:0];
            REG_ID2:   cfg_id[2]  = val[15:0];
            REG_LEN0:  cfg_len[0] = val[2:0];
            REG_LEN1:  cfg_len[1] = val[2:0];
            REG_LEN2:  cfg_len[2] = val[2:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Register read: sample prdata at the edge that ends the access and compare
    // the register's bits with the predictor's copy.
    task automatic check_reg(input logic [2:0] idx);
        logic [31:0] mask;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        mask = cfg_reg_mask(idx);
        if ((prdata & mask) !== cfg_reg_value(idx))
            report_mismatch($sformatf("register %0d read", idx), cfg_reg_value(idx),
                            prdata & mask);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_config(input logic [1:0] count, input logic [15:0] id0,
                               input logic [15:0] id1, input logic [15:0] id2,
                               input logic [2:0] len0, input logic [2:0] len1,
                               input logic [2:0] len2);
        write_reg(REG_COUNT, {30'b0, count});
        write_reg(REG_ID0, {16'b0, id0});
        write_reg(REG_ID1, {16'b0, id1});
        write_reg(REG_ID2, {16'b0, id2});
        write_reg(REG_LEN0, {29'b0, len0});
        write_reg(REG_LEN1, {29'b0, len1});
        write_reg(REG_LEN2, {29'b0, len2});
    endtask

    // Send one request word. Valid stays high from one word to the next unless
    // an idle gap is drawn; junk is driven on the payload while idle.
    task automatic send_req_word(input logic [7:0] b, input logic last);
        int gap;
        gap = 0;
        while (gap < 24 && $urandom_range(99) < req_idle_pct) gap++;
        if (gap > 0) begin
            req_ch.valid    <= 1'b0;
            req_ch.req_byte <= 8'($urandom);
            req_ch.req_last <= 1'($urandom);
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_byte <= b;
        req_ch.req_last <= last;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        predict_request_word(b, last);
        req_words_sent++;
    endtask

    // Send a whole request given as packed bytes, first byte in the upper bits.
    task automatic send_request(input logic [95:0] msg, input int nbytes);
        for (int k = 0; k < nbytes; k++)
            send_req_word(msg[8*(nbytes-1-k) +: 8], k == nbytes - 1);
        requests_sent++;
    endtask

    // Drop valid, wait until every owed word has come, then let the block settle.
    task automatic drain_responses();
        req_ch.valid <= 1'b0;
        while (resp_words_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Mostly well-formed reads and writes of registered identifiers, with some
    // unknown identifiers, other services, odd lengths and pure noise.
    task automatic send_random_request();
        logic [7:0] msg [$];
        int kind;
        int pick;
        int nbytes;
        kind = $urandom_range(99);
        pick = $urandom_range(NUM_ENTRIES - 1);
        if (kind < 85) begin
            if (kind < 40)      msg.push_back(SVC_READ);
            else if (kind < 75) msg.push_back(SVC_WRITE);
            else                msg.push_back($urandom_range(1) ? SVC_READ : SVC_WRITE);
            if (kind < 75) begin
                msg.push_back(cfg_id[pick][15:8]);
                msg.push_back(cfg_id[pick][7:0]);
            end else begin
                msg.push_back(8'($urandom));
                msg.push_back(8'($urandom));
            end
            nbytes = (msg[0] == SVC_WRITE) ? 7 : 3;
            // Cut short or overrun now and then.
            if ($urandom_range(99) < 15) nbytes = $urandom_range(1, 10);
        end else begin
            msg.push_back(8'($urandom));
            nbytes = (kind < 95) ? $urandom_range(1, 8) : $urandom_range(1, 10);
        end
        while (msg.size() < nbytes) msg.push_back(8'($urandom));
        while (msg.size() > nbytes) void'(msg.pop_back());
        for (int k = 0; k < nbytes; k++) send_req_word(msg[k], k == nbytes - 1);
        requests_sent++;
    endtask

    task automatic run_random_phase(input int idle_pct, input int stall_pct);
        int start_words;
        req_idle_pct   = idle_pct;
        resp_stall_pct = stall_pct;
        start_words    = req_words_sent;
        while (req_words_sent - start_words < PHASE_WORDS) send_random_request();
        drain_responses();
    endtask

    // Reset values read back, then every field bit set and read back.
    task automatic test_register_access();
        for (int i = 0; i <= REG_LEN2; i++) check_reg(3'(i));
        load_config(2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd7, 3'd7, 3'd7);
        for (int i = 0; i <= REG_LEN2; i++) check_reg(3'(i));
        load_config(2'd0, 16'h0000, 16'h0000, 16'h0000, 3'd4, 3'd4, 3'd4);
    endtask

    // With no registered entries even identifier zero is unknown.
    task automatic test_no_entries();
        send_request({SVC_READ, 8'h00, 8'h00}, 3);
        drain_responses();
    endtask

    task automatic test_read_write_hits();
        load_config(2'd3, 16'h1234, 16'hABCD, 16'hFFFF, 3'd4, 3'd0, 3'd7);
        // Overlong write: the two trailing bytes are dropped.
        send_request({SVC_WRITE, 8'h12, 8'h34, 8'hA1, 8'hB2, 8'hC3, 8'hD4, 8'hE5,
                      8'hF6}, 9);
        send_request({SVC_READ, 8'h12, 8'h34}, 3);
        // Zero length: header only.
        send_request({SVC_READ, 8'hAB, 8'hCD}, 3);
        // Short write: missing data bytes read as zero.
        send_request({SVC_WRITE, 8'hFF, 8'hFF}, 3);
        // Length register above four returns four bytes.
        send_request({SVC_READ, 8'hFF, 8'hFF}, 3);
        drain_responses();
    endtask

    task automatic test_unknown_and_other();
        send_request({SVC_WRITE, 8'h00, 8'h01}, 3);
        send_request({8'h10}, 1);
        send_request({8'hFF, 8'h22}, 2);
        drain_responses();
    endtask

    // Four idle/stall phases, each under its own register setting.
    task automatic test_random_traffic();
        load_config(2'd3, 16'($urandom), 16'($urandom), 16'($urandom), 3'd4, 3'd0, 3'd7);
        run_random_phase(0, 0);
        load_config(2'd1, 16'hFFFF, 16'h0000, 16'($urandom), 3'($urandom), 3'($urandom),
                    3'($urandom));
        run_random_phase(70, 0);
        // Duplicate identifiers: the lower entry must win.
        load_config(2'd2, 16'h5A5A, 16'h5A5A, 16'hA5A5, 3'd1, 3'd2, 3'd3);
        run_random_phase(0, 70);
        load_config(2'd3, 16'($urandom), 16'($urandom), 16'h0000, 3'($urandom),
                    3'($urandom), 3'd4);
        run_random_phase(22, 22);
    endtask

    initial begin
        // Hold every input at a known value and clear the predictor.
        i_rst_n         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        req_ch.valid    = 1'b0;
        req_ch.req_byte = 8'h00;
        req_ch.req_last = 1'b0;
        resp_ch.ready   = 1'b1;
        cfg_count       = 2'd0;
        msg_fill        = 0;
        for (int i = 0; i < MSG_BYTES; i++) msg_buf[i] = 8'h00;
        for (int i = 0; i < NUM_ENTRIES; i++) entry_value[i] = 32'h0;
        for (int i = 0; i < CFG_ENTRIES; i++) begin
            cfg_id[i]  = 16'h0000;
            cfg_len[i] = LEN_MAX;
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_register_access();
        test_no_entries();
        test_read_write_hits();
        test_unknown_and_other();
        test_random_traffic();

        $display("covered %0d requests in %0d request words, %0d response words checked,",
                 requests_sent, req_words_sent, resp_words_seen);
        $display("over reads, writes, unknown ids, other services and four idle phases");
        if (mismatch_count == 0 && resp_words_due.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches, %0d words still owed", mismatch_count,
                     resp_words_due.size());
            $display("simulation failed");
        end
        $finish;
    end

endmodule
